/* rtl/core/cpba_pkg.sv */
// shared constants, codes and token type for the chained pool bump allocator
package cpba_pkg;

  // pool geometry
  localparam int POOL_BYTES = 32768;
  localparam int MAX_POOLS  = 16;

  // field and storage widths
  localparam int SIZE_W = 16;
  localparam int FILL_W = 16;
  localparam int IDX_W  = 4;
  localparam int ROOM_W = FILL_W + 1;

  localparam logic [ROOM_W-1:0] POOL_BYTES_R = ROOM_W'(POOL_BYTES);

  // request actions
  typedef enum logic [1:0] {
    ACT_LAST    = 2'd0,
    ACT_FIRST   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_NO_POOL = 2'd2
  } status_t;

  // request token walking down the pool chain
  typedef struct packed {
    logic              valid;
    logic              last_only;
    logic [SIZE_W-1:0] size;
    logic              claimed;
    logic [IDX_W-1:0]  idx;
    logic [FILL_W-1:0] off;
  } cpba_tok_t;

endpackage

/* rtl/core/cpba_cell.sv */
// one pool of the chain: open flag, fill level and one token stage
module cpba_cell
  import cpba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,        // release all pools
  input  logic [IDX_W-1:0] cell_idx,   // fixed position in the chain
  input  logic             next_open,  // open flag of the next pool
  input  cpba_tok_t        tok_i,
  output logic             open_o,
  output cpba_tok_t        tok_o
);

  logic              open_r, open_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  cpba_tok_t         tok_r, tok_nxt;

  logic [ROOM_W-1:0] room;
  logic              fits;
  logic              eligible;
  logic              take_open;
  logic              take_new;
  logic              home;

  assign home = (cell_idx == '0);

  // room check against this pool's fill
  assign room      = POOL_BYTES_R - {1'b0, fill_r};
  assign fits      = ({1'b0, tok_i.size} <= room);
  assign eligible  = open_r && fits && (!tok_i.last_only || !next_open);
  assign take_open = tok_i.valid && !tok_i.claimed && eligible;
  // first closed pool opens fresh for an unserved request
  assign take_new  = tok_i.valid && !tok_i.claimed && !open_r;

  // state and token update
  always_comb begin
    open_nxt = open_r;
    fill_nxt = fill_r;
    tok_nxt  = tok_i;
    if (take_open) begin
      fill_nxt        = fill_r + tok_i.size;
      tok_nxt.claimed = 1'b1;
      tok_nxt.idx     = cell_idx;
      tok_nxt.off     = fill_r;
    end else if (take_new) begin
      open_nxt        = 1'b1;
      fill_nxt        = tok_i.size;
      tok_nxt.claimed = 1'b1;
      tok_nxt.idx     = cell_idx;
      tok_nxt.off     = '0;
    end
    if (clr) begin
      open_nxt = home;
      fill_nxt = '0;
    end
  end

  // pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= home;
      fill_r <= '0;
    end else begin
      open_r <= open_nxt;
      fill_r <= fill_nxt;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign open_o = open_r;
  assign tok_o  = tok_r;

endmodule

/* rtl/core/chained_pool_bump_allocator.sv */
// top level of the chained pool bump allocator
//
// Requests enter on the in_ stream (action and size), one result word per
// request leaves on the out_ stream (status, pool index, offset).
// Allocations walk a chain of MAX_POOLS pool cells, one cell per cycle; the
// first cell that can serve the request claims it, and the first closed
// cell opens as a fresh pool when no open one fits.
// The result of an allocation passes the token register of every cell in the
// chain, then the done register and the output register; release, oversize
// and undefined actions skip the chain and load the done register directly.
// One request is worked on at a time; in_tready rises again once the result
// has moved into the output register, so the next request is taken while a
// result still waits there.
// When the receiver stalls, the result holds in the output register and one
// more finished result holds behind it; further requests wait.
// Reset leaves one open empty pool, as does a release.
module chained_pool_bump_allocator
  import cpba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] action, [17:2] byte count, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [5:2] pool_index, [21:6] offset
);

  logic              busy_r;
  logic              done_valid_r;
  status_t           done_status_r;
  logic [IDX_W-1:0]  done_idx_r;
  logic [FILL_W-1:0] done_off_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [FILL_W-1:0] out_off_r;

  logic              in_acc;
  action_t           act;
  logic [SIZE_W-1:0] req_len;
  logic              too_big;
  logic              launch;
  logic              imm_load;
  status_t           imm_status;
  logic              clr;
  logic              move_out;
  cpba_tok_t         launch_tok;
  cpba_tok_t         end_tok;

  cpba_tok_t              tok_in  [MAX_POOLS];
  cpba_tok_t              tok_q   [MAX_POOLS];
  logic [MAX_POOLS-1:0]   open_vec;
  logic [MAX_POOLS-1:0]   tok_valid_vec;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign act       = action_t'(in_tdata[1:0]);
  assign req_len   = in_tdata[17:2];
  assign too_big   = ({1'b0, req_len} > POOL_BYTES_R);

  // request decode
  always_comb begin
    launch     = 1'b0;
    imm_load   = 1'b0;
    imm_status = ST_OK;
    clr        = 1'b0;
    unique case (act)
      ACT_LAST, ACT_FIRST: begin
        if (too_big) begin
          imm_load   = in_acc;
          imm_status = ST_TOO_BIG;
        end else begin
          launch = in_acc;
        end
      end
      ACT_RELEASE: begin
        imm_load = in_acc;
        clr      = in_acc;
      end
      default: begin
        imm_load = in_acc;
      end
    endcase
  end

  // token entering the first cell
  always_comb begin
    launch_tok           = '0;
    launch_tok.valid     = launch;
    launch_tok.last_only = (act == ACT_LAST);
    launch_tok.size      = req_len;
  end

  // pool cell chain
  for (genvar i = 0; i < MAX_POOLS; i++) begin : g_cell
    logic nxt_open;
    if (i == 0) begin : g_head
      assign tok_in[i] = launch_tok;
    end else begin : g_link
      assign tok_in[i] = tok_q[i-1];
    end
    if (i == MAX_POOLS - 1) begin : g_tail
      assign nxt_open = 1'b0;
    end else begin : g_mid
      assign nxt_open = open_vec[i+1];
    end

    cpba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (clr),
      .cell_idx (IDX_W'(i)),
      .next_open(nxt_open),
      .tok_i    (tok_in[i]),
      .open_o   (open_vec[i]),
      .tok_o    (tok_q[i])
    );

    assign tok_valid_vec[i] = tok_q[i].valid;
  end

  assign end_tok  = tok_q[MAX_POOLS-1];
  assign move_out = done_valid_r && (!out_valid_r || out_tready);

  // handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      done_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (move_out) begin
        out_valid_r  <= 1'b1;
        done_valid_r <= 1'b0;
        busy_r       <= 1'b0;
      end
      if (launch || imm_load) begin
        busy_r <= 1'b1;
      end
      if (imm_load || end_tok.valid) begin
        done_valid_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (imm_load) begin
      done_status_r <= imm_status;
      done_idx_r    <= '0;
      done_off_r    <= '0;
    end else if (end_tok.valid) begin
      done_status_r <= end_tok.claimed ? ST_OK : ST_NO_POOL;
      done_idx_r    <= end_tok.claimed ? end_tok.idx : '0;
      done_off_r    <= end_tok.claimed ? end_tok.off : '0;
    end
    if (move_out) begin
      out_status_r <= done_status_r;
      out_idx_r    <= done_idx_r;
      out_off_r    <= done_off_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_off_r, out_idx_r, out_status_r};

`ifndef NO_ASSERTIONS
  // pool zero is always open
  a_home_open: assert property (@(posedge clk) disable iff (!rst_n) open_vec[0])
    else $error("pool zero closed");

  // open pools form a run starting at pool zero
  a_open_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((open_vec + MAX_POOLS'(1)) & open_vec) == '0)
    else $error("open pools not contiguous");

  // at most one request token in the chain
  a_one_tok: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_valid_vec))
    else $error("more than one token in chain");

  // a token in flight keeps the input closed
  a_busy_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_valid_vec != '0) |-> busy_r)
    else $error("token in chain while idle");

  // a finished result never overwrites a pending one
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    end_tok.valid |-> !done_valid_r)
    else $error("result slot overrun");
`endif

endmodule
